/* design/tcst_pkg.sv */
// Shared types and constants for the TCP connection state tracker.
// Holds the state codes, the classified segment item and the timeout register set.
// No dependencies.
package tcst_pkg;

   // Per-side connection state codes
   typedef enum logic [3:0] {
      ST_LISTEN      = 4'd0,
      ST_SYN_OUT     = 4'd1,
      ST_SYN_IN      = 4'd2,
      ST_ESTABLISHED = 4'd3,
      ST_PEER_FIN    = 4'd4,
      ST_FIN_OUT     = 4'd5,
      ST_CLOSING     = 4'd6,
      ST_LAST_FIN    = 4'd7,
      ST_FIN_ACKED   = 4'd8,
      ST_TIME_WAIT   = 4'd9,
      ST_CLOSED      = 4'd10
   } tcp_state_type;

   localparam int TIMEOUT_W = 16;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_LISTEN_CLOSED = 3'd0;
   localparam logic [2:0] REG_SYN_OUT       = 3'd1;
   localparam logic [2:0] REG_SYN_IN        = 3'd2;
   localparam logic [2:0] REG_ESTABLISHED   = 3'd3;
   localparam logic [2:0] REG_PEER_FIN      = 3'd4;
   localparam logic [2:0] REG_FIN_OUT       = 3'd5;
   localparam logic [2:0] REG_LAST_FIN      = 3'd6;
   localparam logic [2:0] REG_TIME_WAIT     = 3'd7;

   // Reset values, seconds
   localparam logic [TIMEOUT_W-1:0] RST_LISTEN_CLOSED = 16'd10;
   localparam logic [TIMEOUT_W-1:0] RST_SYN_OUT       = 16'd120;
   localparam logic [TIMEOUT_W-1:0] RST_SYN_IN        = 16'd60;
   localparam logic [TIMEOUT_W-1:0] RST_ESTABLISHED   = 16'd3600;
   localparam logic [TIMEOUT_W-1:0] RST_PEER_FIN      = 16'd60;
   localparam logic [TIMEOUT_W-1:0] RST_FIN_OUT       = 16'd120;
   localparam logic [TIMEOUT_W-1:0] RST_LAST_FIN      = 16'd30;
   localparam logic [TIMEOUT_W-1:0] RST_TIME_WAIT     = 16'd10;

   // Idle timeout set as seen by the back end
   typedef struct packed {
      logic [TIMEOUT_W-1:0] listen_closed;
      logic [TIMEOUT_W-1:0] syn_out;
      logic [TIMEOUT_W-1:0] syn_in;
      logic [TIMEOUT_W-1:0] established;
      logic [TIMEOUT_W-1:0] peer_fin;
      logic [TIMEOUT_W-1:0] fin_out;
      logic [TIMEOUT_W-1:0] last_fin;
      logic [TIMEOUT_W-1:0] time_wait;
   } timeout_set_type;

   // Classified segment item
   typedef struct packed {
      logic direction;
      logic rst;
      logic syn;
      logic ack;
      logic fin;
      logic ack_only;   // ACK without SYN or FIN
      logic syn_ack;    // SYN and ACK together
   } seg_type;

   // Queue status towards front and back
   typedef struct packed {
      logic ready;      // queue can take an item this cycle
      logic valid;      // head item present
   } queue_status_type;

endpackage

/* design/tcp_connection_state_tracker.sv */
// Top level of the TCP connection state tracker.
// Instantiates tcst_csr, tcst_front, tcst_queue and tcst_back; depends on tcst_pkg.
//
// Usage:
//   Request channel (req_*): one item per TCP segment, carrying the sending side and
//   the SYN/ACK/FIN/RST flags. Taken when req_valid and req_ready are both high.
//   Response channel (rsp_*): one item per request: change flag, idle timeout for the
//   sender's new state, and the new state of both sides.
//   Configuration (csr_*): eight 16-bit idle timeout registers at byte offsets 0..28,
//   two-phase APB-style writes, pready tied high. Write only while no item is in flight.
//
// Flow and throughput:
//   A request taken is written into the queue; the back end pops it and registers its
//   result in the response register. The state update is a read-modify-write of the
//   two 4-bit side registers in the back end, so one item per clock is sustained while
//   rsp_ready is high. A two-entry queue sits between the flag decode and the back end.
//
// Reset and stalls:
//   Synchronous reset puts both sides in LISTEN, loads the default timeouts and empties
//   the queue. While rsp_ready is low a pending response holds; the queue keeps
//   accepting until both entries are occupied, then req_ready drops.
module tcp_connection_state_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_direction,
   input  logic                          req_syn_flag,
   input  logic                          req_ack_flag,
   input  logic                          req_fin_flag,
   input  logic                          req_rst_flag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_state_changed,
   output logic [tcst_pkg::TIMEOUT_W-1:0] rsp_timeout_value,
   output logic [3:0]                    rsp_sender_state,
   output logic [3:0]                    rsp_peer_state,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tcst_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tcst_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tcst_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import tcst_pkg::*;

   timeout_set_type  timeouts;
   queue_status_type q_status;
   seg_type          push_seg;
   seg_type          head_seg;
   logic             push;
   logic             pop;

   tcst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timeouts    (timeouts)
   );

   tcst_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_direction (req_direction),
      .req_syn_flag  (req_syn_flag),
      .req_ack_flag  (req_ack_flag),
      .req_fin_flag  (req_fin_flag),
      .req_rst_flag  (req_rst_flag),
      .q_status      (q_status),
      .push          (push),
      .push_seg      (push_seg)
   );

   tcst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_seg (push_seg),
      .pop      (pop),
      .head_seg (head_seg),
      .status   (q_status)
   );

   tcst_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .head_seg          (head_seg),
      .pop               (pop),
      .timeouts          (timeouts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_state_changed (rsp_state_changed),
      .rsp_timeout_value (rsp_timeout_value),
      .rsp_sender_state  (rsp_sender_state),
      .rsp_peer_state    (rsp_peer_state)
   );

endmodule

/* design/tcst_csr.sv */
// Configuration registers for the tracker: eight idle timeouts on an APB-style port.
// Depends on tcst_pkg.
module tcst_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tcst_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tcst_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tcst_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output tcst_pkg::timeout_set_type   timeouts
);
   import tcst_pkg::*;

   timeout_set_type     regs_ff;
   logic [2:0]          reg_idx;
   logic                wr_en;
   logic [TIMEOUT_W-1:0] wr_data;
   logic [TIMEOUT_W-1:0] rd_data;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wr_data    = csr_pwdata[TIMEOUT_W-1:0];

   // Register write, access phase only
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.listen_closed <= RST_LISTEN_CLOSED;
         regs_ff.syn_out       <= RST_SYN_OUT;
         regs_ff.syn_in        <= RST_SYN_IN;
         regs_ff.established   <= RST_ESTABLISHED;
         regs_ff.peer_fin      <= RST_PEER_FIN;
         regs_ff.fin_out       <= RST_FIN_OUT;
         regs_ff.last_fin      <= RST_LAST_FIN;
         regs_ff.time_wait     <= RST_TIME_WAIT;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_LISTEN_CLOSED: regs_ff.listen_closed <= wr_data;
            REG_SYN_OUT:       regs_ff.syn_out       <= wr_data;
            REG_SYN_IN:        regs_ff.syn_in        <= wr_data;
            REG_ESTABLISHED:   regs_ff.established   <= wr_data;
            REG_PEER_FIN:      regs_ff.peer_fin      <= wr_data;
            REG_FIN_OUT:       regs_ff.fin_out       <= wr_data;
            REG_LAST_FIN:      regs_ff.last_fin      <= wr_data;
            REG_TIME_WAIT:     regs_ff.time_wait     <= wr_data;
            default:           regs_ff <= regs_ff;
         endcase
      end
   end

   // Read-back mux
   always_comb begin
      unique case (reg_idx)
         REG_LISTEN_CLOSED: rd_data = regs_ff.listen_closed;
         REG_SYN_OUT:       rd_data = regs_ff.syn_out;
         REG_SYN_IN:        rd_data = regs_ff.syn_in;
         REG_ESTABLISHED:   rd_data = regs_ff.established;
         REG_PEER_FIN:      rd_data = regs_ff.peer_fin;
         REG_FIN_OUT:       rd_data = regs_ff.fin_out;
         REG_LAST_FIN:      rd_data = regs_ff.last_fin;
         REG_TIME_WAIT:     rd_data = regs_ff.time_wait;
         default:           rd_data = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DW-TIMEOUT_W){1'b0}}, rd_data};
   assign timeouts   = regs_ff;

endmodule

/* design/tcst_front.sv */
// Front end: takes segment items off the request channel and classifies the flags.
// Depends on tcst_pkg.
module tcst_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_direction,
   input  logic                       req_syn_flag,
   input  logic                       req_ack_flag,
   input  logic                       req_fin_flag,
   input  logic                       req_rst_flag,
   input  tcst_pkg::queue_status_type q_status,
   output logic                       push,
   output tcst_pkg::seg_type          push_seg
);
   import tcst_pkg::*;

   // Accept whenever the queue has room
   assign req_ready = q_status.ready;
   assign push      = req_valid & q_status.ready;

   // Flag decode shared by several transitions
   always_comb begin
      push_seg.direction = req_direction;
      push_seg.rst       = req_rst_flag;
      push_seg.syn       = req_syn_flag;
      push_seg.ack       = req_ack_flag;
      push_seg.fin       = req_fin_flag;
      push_seg.ack_only  = req_ack_flag & ~req_syn_flag & ~req_fin_flag;
      push_seg.syn_ack   = req_syn_flag & req_ack_flag;
   end

endmodule

/* design/tcst_queue.sv */
// Two-entry item queue between front and back ends.
// Depends on tcst_pkg.
module tcst_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tcst_pkg::seg_type          push_seg,
   input  logic                       pop,
   output tcst_pkg::seg_type          head_seg,
   output tcst_pkg::queue_status_type status
);
   import tcst_pkg::*;

   seg_type    data_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       full;

   assign full = (count_ff == 2'd2);

   // Room when not full, or when the head leaves this cycle
   assign status.ready = ~full | pop;
   assign status.valid = (count_ff != 2'd0);
   assign head_seg     = data_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop & ~push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_seg;
      end
   end

endmodule

/* design/tcst_back.sv */
// Back end: applies the transition table to both side states and registers the result item.
// Depends on tcst_pkg.
module tcst_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tcst_pkg::queue_status_type    q_status,
   input  tcst_pkg::seg_type             head_seg,
   output logic                          pop,
   input  tcst_pkg::timeout_set_type     timeouts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_state_changed,
   output logic [tcst_pkg::TIMEOUT_W-1:0] rsp_timeout_value,
   output logic [3:0]                    rsp_sender_state,
   output logic [3:0]                    rsp_peer_state
);
   import tcst_pkg::*;

   tcp_state_type        orig_ff;
   tcp_state_type        resp_ff;
   tcp_state_type        s_cur;
   tcp_state_type        o_cur;
   tcp_state_type        ns;
   tcp_state_type        np_raw;
   tcp_state_type        np;
   logic                 forced;
   logic                 changed;
   logic [TIMEOUT_W-1:0] timeout_sel;

   logic                 rsp_valid_ff;
   logic                 changed_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   tcp_state_type        sender_ff;
   tcp_state_type        peer_ff;

   // Take the head item when the output register is free or being drained
   assign pop = q_status.valid & (~rsp_valid_ff | rsp_ready);

   assign s_cur = head_seg.direction ? resp_ff : orig_ff;
   assign o_cur = head_seg.direction ? orig_ff : resp_ff;

   // Transition table for the sending side; some transitions also move the peer
   always_comb begin
      ns     = s_cur;
      np_raw = o_cur;
      forced = 1'b0;
      if (head_seg.rst) begin
         ns     = ST_TIME_WAIT;
         np_raw = ST_TIME_WAIT;
         forced = 1'b1;
      end else begin
         unique case (s_cur)
            ST_LISTEN: begin
               if (head_seg.syn_ack) begin
                  ns = ST_SYN_IN;
               end else if (head_seg.syn) begin
                  ns = ST_SYN_OUT;
               end else if (head_seg.ack_only) begin
                  ns = ST_ESTABLISHED;
               end
            end
            ST_SYN_OUT: begin
               if (head_seg.syn & ~head_seg.ack) begin
                  ns = ST_SYN_OUT;
               end else if (head_seg.ack_only) begin
                  ns = ST_ESTABLISHED;
               end else if (head_seg.fin) begin
                  ns = ST_FIN_OUT;
               end else if (head_seg.syn_ack) begin
                  ns = ST_SYN_IN;
               end
            end
            ST_SYN_IN: begin
               if (head_seg.ack_only) begin
                  ns = ST_ESTABLISHED;
               end else if (head_seg.syn_ack) begin
                  ns = ST_SYN_IN;
               end else if (head_seg.fin) begin
                  ns = ST_FIN_OUT;
               end
            end
            ST_ESTABLISHED: begin
               if (head_seg.fin) begin
                  ns = (o_cur == ST_FIN_OUT) ? ST_CLOSING : ST_FIN_OUT;
               end else if (head_seg.ack) begin
                  if (o_cur == ST_TIME_WAIT) begin
                     ns = ST_TIME_WAIT;
                  end else if (o_cur == ST_FIN_OUT) begin
                     ns     = ST_PEER_FIN;
                     np_raw = ST_FIN_ACKED;
                  end
               end
            end
            ST_PEER_FIN: begin
               if (head_seg.fin) begin
                  ns = ST_LAST_FIN;
               end
            end
            ST_FIN_OUT: begin
               if (head_seg.ack && (o_cur > ST_PEER_FIN)) begin
                  ns = ST_TIME_WAIT;
               end
            end
            ST_CLOSING: begin
               if (head_seg.ack & ~head_seg.fin) begin
                  ns = ST_TIME_WAIT;
               end
            end
            ST_FIN_ACKED: begin
               if (head_seg.ack) begin
                  ns     = ST_TIME_WAIT;
                  np_raw = ST_TIME_WAIT;
               end
            end
            ST_TIME_WAIT: begin
               forced = 1'b1;
            end
            default: begin
               ns = s_cur;
            end
         endcase
      end
   end

   // Change is judged before the peer is pulled to ESTABLISHED
   assign changed = forced | (ns != s_cur) | (np_raw != o_cur);
   assign np      = (ns == ST_ESTABLISHED) ? ST_ESTABLISHED : np_raw;

   // Timeout for the sender's new state
   always_comb begin
      unique case (ns)
         ST_LISTEN, ST_CLOSED:      timeout_sel = timeouts.listen_closed;
         ST_SYN_OUT:                timeout_sel = timeouts.syn_out;
         ST_SYN_IN:                 timeout_sel = timeouts.syn_in;
         ST_ESTABLISHED:            timeout_sel = timeouts.established;
         ST_PEER_FIN, ST_CLOSING:   timeout_sel = timeouts.peer_fin;
         ST_FIN_OUT:                timeout_sel = timeouts.fin_out;
         ST_LAST_FIN, ST_FIN_ACKED: timeout_sel = timeouts.last_fin;
         ST_TIME_WAIT:              timeout_sel = timeouts.time_wait;
         default:                   timeout_sel = '0;
      endcase
   end

   // Side state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         orig_ff      <= ST_LISTEN;
         resp_ff      <= ST_LISTEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            orig_ff <= head_seg.direction ? np : ns;
            resp_ff <= head_seg.direction ? ns : np;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         changed_ff <= changed;
         timeout_ff <= timeout_sel;
         sender_ff  <= ns;
         peer_ff    <= np;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_state_changed = changed_ff;
   assign rsp_timeout_value = timeout_ff;
   assign rsp_sender_state  = sender_ff;
   assign rsp_peer_state    = peer_ff;

`ifndef SYNTH
   // A reset segment leaves both sides in TIME_WAIT
   a_rst_time_wait: assert property (@(posedge clock) disable iff (reset)
      (pop && head_seg.rst) |=> (orig_ff == ST_TIME_WAIT && resp_ff == ST_TIME_WAIT))
      else $error("RST segment did not force both sides to TIME_WAIT");

   // Sender reaching ESTABLISHED drags the peer along
   a_peer_established: assert property (@(posedge clock) disable iff (reset)
      (pop && ns == ST_ESTABLISHED) |=> (orig_ff == ST_ESTABLISHED &&
                                         resp_ff == ST_ESTABLISHED))
      else $error("peer not forced to ESTABLISHED");

   // Every popped item shows up as a result item
   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped item produced no result");

   // Side states stay within the defined codes
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      (orig_ff <= ST_CLOSED) && (resp_ff <= ST_CLOSED))
      else $error("side state left the defined range");
`endif

endmodule

/* sim/tb_tcp_connection_state_tracker.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tcp_connection_state_tracker: drives segments and timeout
// registers, predicts every result in-bench and compares it field by field.
// Depends on tcst_pkg and the tracker RTL only.
module tb_tcp_connection_state_tracker;
   import tcst_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;

   localparam logic [2:0] ALL_REGS [8] = '{REG_LISTEN_CLOSED, REG_SYN_OUT, REG_SYN_IN,
      REG_ESTABLISHED, REG_PEER_FIN, REG_FIN_OUT, REG_LAST_FIN, REG_TIME_WAIT};

   typedef struct packed {
      logic dir;
      logic syn;
      logic ack;
      logic fin;
      logic rst;
   } segment_type;

   typedef struct packed {
      logic                 changed;
      logic [TIMEOUT_W-1:0] timeout;
      tcp_state_type        sender;
      tcp_state_type        peer;
   } tracker_update_type;

   typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} timeout_fill_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid, req_ready;
   logic                 req_direction, req_syn_flag, req_ack_flag, req_fin_flag;
   logic                 req_rst_flag;
   logic                 rsp_valid, rsp_ready;
   logic                 rsp_state_changed;
   logic [TIMEOUT_W-1:0] rsp_timeout_value;
   logic [3:0]           rsp_sender_state, rsp_peer_state;
   logic                 csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0]    csr_paddr;
   logic [CSR_DW-1:0]    csr_pwdata, csr_prdata;
   logic                 csr_pready;

   // predicted connection and timeout registers
   tcp_state_type        conn_side [2];
   logic [TIMEOUT_W-1:0] timeout_regs [8];
   tracker_update_type   awaited_updates [$];

   int mismatch_count = 0;
   int results_seen   = 0;
   int cycle_count    = 0;
   int gap_pct        = 0;
   int stall_pct      = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   int hold_left      = 0;

   tcp_connection_state_tracker uut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- prediction
   function automatic logic [TIMEOUT_W-1:0] timeout_for(tcp_state_type st);
      case (st)
         ST_LISTEN, ST_CLOSED:       return timeout_regs[REG_LISTEN_CLOSED];
         ST_SYN_OUT:                 return timeout_regs[REG_SYN_OUT];
         ST_SYN_IN:                  return timeout_regs[REG_SYN_IN];
         ST_ESTABLISHED:             return timeout_regs[REG_ESTABLISHED];
         ST_PEER_FIN, ST_CLOSING:    return timeout_regs[REG_PEER_FIN];
         ST_FIN_OUT:                 return timeout_regs[REG_FIN_OUT];
         ST_LAST_FIN, ST_FIN_ACKED:  return timeout_regs[REG_LAST_FIN];
         ST_TIME_WAIT:               return timeout_regs[REG_TIME_WAIT];
         default:                    return '0;
      endcase
   endfunction

   // s is the sender's state, o the peer's, both before the segment
   function automatic tracker_update_type next_update(segment_type sg, tcp_state_type s,
                                                      tcp_state_type o);
      tcp_state_type      ns;
      tcp_state_type      np;
      logic               chg;
      tracker_update_type upd;
      ns  = s;
      np  = o;
      chg = 1'b0;
      if (sg.rst) begin
         ns  = ST_TIME_WAIT;
         np  = ST_TIME_WAIT;
         chg = 1'b1;
      end else begin
         case (s)
            ST_LISTEN: begin
               if (sg.syn && sg.ack) ns = ST_SYN_IN;
               else if (sg.syn) ns = ST_SYN_OUT;
               else if (!sg.fin && sg.ack) ns = ST_ESTABLISHED;
            end
            ST_SYN_OUT: begin
               if (sg.syn && !sg.ack) ns = s;
               else if (!sg.syn && !sg.fin && sg.ack) ns = ST_ESTABLISHED;
               else if (sg.fin) ns = ST_FIN_OUT;
               else if (sg.syn && sg.ack) ns = ST_SYN_IN;
            end
            ST_SYN_IN: begin
               if (!sg.syn && !sg.fin && sg.ack) ns = ST_ESTABLISHED;
               else if (sg.syn && sg.ack) ns = s;
               else if (sg.fin) ns = ST_FIN_OUT;
            end
            ST_ESTABLISHED: begin
               if (sg.fin) begin
                  ns = (o == ST_FIN_OUT) ? ST_CLOSING : ST_FIN_OUT;
               end else if (sg.ack) begin
                  if (o == ST_TIME_WAIT) begin
                     ns = ST_TIME_WAIT;
                  end else if (o == ST_FIN_OUT) begin
                     // peer's FIN acknowledged
                     ns = ST_PEER_FIN;
                     np = ST_FIN_ACKED;
                  end
               end
            end
            ST_PEER_FIN: ns = sg.fin ? ST_LAST_FIN : ST_PEER_FIN;
            ST_FIN_OUT: begin
               if (sg.ack && o > ST_PEER_FIN) ns = ST_TIME_WAIT;
            end
            ST_CLOSING: begin
               if (!sg.fin && sg.ack) ns = ST_TIME_WAIT;
            end
            ST_FIN_ACKED: begin
               if (sg.ack) begin
                  ns = ST_TIME_WAIT;
                  np = ST_TIME_WAIT;
               end
            end
            ST_TIME_WAIT: chg = 1'b1;
            default: ;
         endcase
      end
      if (!chg) chg = (np != o) || (ns != s);
      // an established sender drags the peer along, without raising the flag
      if (ns == ST_ESTABLISHED) np = ST_ESTABLISHED;
      upd.changed = chg;
      upd.timeout = timeout_for(ns);
      upd.sender  = ns;
      upd.peer    = np;
      return upd;
   endfunction

   function automatic segment_type segment(logic d, logic syn, logic ack, logic fin,
                                           logic rst);
      segment_type sg;
      sg.dir = d;
      sg.syn = syn;
      sg.ack = ack;
      sg.fin = fin;
      sg.rst = rst;
      return sg;
   endfunction

   // random segment that leaves one side able to reopen the connection
   function automatic segment_type draw_live_segment();
      segment_type        sg;
      tracker_update_type upd;
      repeat (20) begin
         sg = segment(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), $urandom_range(15) == 0);
         upd = next_update(sg, conn_side[sg.dir], conn_side[!sg.dir]);
         if (upd.sender <= ST_ESTABLISHED || upd.peer <= ST_ESTABLISHED) return sg;
      end
      // a bare segment from the live side never raises the change flag
      sg = '0;
      sg.dir = (conn_side[1] <= ST_ESTABLISHED);
      return sg;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s on result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      tracker_update_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_updates.size() == 0) begin
            report_mismatch("result with nothing outstanding", 32'(rsp_sender_state), 0);
         end else begin
            want = awaited_updates.pop_front();
            if (rsp_state_changed !== want.changed)
               report_mismatch("state_changed", 32'(rsp_state_changed), 32'(want.changed));
            if (rsp_timeout_value !== want.timeout)
               report_mismatch("timeout_value", 32'(rsp_timeout_value), 32'(want.timeout));
            if (rsp_sender_state !== want.sender)
               report_mismatch("sender_state", 32'(rsp_sender_state), 32'(want.sender));
            if (rsp_peer_state !== want.peer)
               report_mismatch("peer_state", 32'(rsp_peer_state), 32'(want.peer));
         end
         results_seen++;
      end
   end

   // result side: random stalls, plus a long hold when asked for
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers
   // called just after a rising edge; returns at the edge that takes the item
   task automatic send_segment(segment_type sg);
      tracker_update_type upd;
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      upd = next_update(sg, conn_side[sg.dir], conn_side[!sg.dir]);
      conn_side[sg.dir]  = upd.sender;
      conn_side[!sg.dir] = upd.peer;
      awaited_updates.push_back(upd);
      req_valid     <= 1'b1;
      req_direction <= sg.dir;
      req_syn_flag  <= sg.syn;
      req_ack_flag  <= sg.ack;
      req_fin_flag  <= sg.fin;
      req_rst_flag  <= sg.rst;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (awaited_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one APB transfer; transfers run back to back, the caller frees the bus
   task automatic csr_access(bit wr, logic [2:0] idx, logic [TIMEOUT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (wr) timeout_regs[idx] = value;
      else if (csr_prdata !== {16'h0, timeout_regs[idx]})
         report_mismatch("timeout register readback", csr_prdata,
                         32'(timeout_regs[idx]));
   endtask

   // only while the tracker is idle
   task automatic program_timeouts(timeout_fill_type fill);
      logic [TIMEOUT_W-1:0] value;
      settle_block();
      foreach (ALL_REGS[i]) begin
         case (fill)
            FILL_ZERO: value = '0;
            FILL_ONES: value = '1;
            default:   value = 16'($urandom);
         endcase
         csr_access(1'b1, ALL_REGS[i], value);
         csr_access(1'b0, ALL_REGS[i], '0);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(int gap, int stall);
      gap_pct   = gap;
      stall_pct = stall;
   endtask

   // ---------------------------------------------------------------- tests
   // opening handshake from reset with default timeouts, ending with both sides up
   task automatic test_handshake();
      set_idling(0, 0);
      send_segment(segment(0, 0, 0, 0, 0));   // LISTEN ignores a bare segment
      send_segment(segment(0, 0, 0, 1, 0));   // and a lone FIN
      send_segment(segment(0, 1, 0, 0, 0));   // SYN opens actively
      send_segment(segment(0, 1, 0, 0, 0));   // repeated SYN holds
      send_segment(segment(1, 0, 1, 1, 0));   // ACK+FIN in LISTEN holds
      send_segment(segment(1, 1, 1, 0, 0));   // SYN+ACK opens passively
      send_segment(segment(1, 1, 1, 1, 0));   // SYN+ACK holds the passive open
      send_segment(segment(0, 1, 1, 0, 0));   // crossing SYN+ACK
      send_segment(segment(0, 0, 0, 1, 0));   // early FIN from the half-open side
      send_segment(segment(1, 0, 1, 0, 0));   // ACK -> ESTABLISHED, peer forced up
      send_segment(segment(0, 0, 0, 0, 0));
      send_segment(segment(1, 0, 1, 0, 0));
      send_segment(segment(0, 0, 0, 1, 0));   // half close
      send_segment(segment(1, 1, 0, 0, 0));   // peer forced back, flag stays low
      send_segment(segment(1, 0, 0, 1, 0));
      send_segment(segment(0, 0, 0, 0, 0));   // reopened again
   endtask

   task automatic test_register_extremes();
      program_timeouts(FILL_ONES);
      repeat (8) send_segment(draw_live_segment());
      program_timeouts(FILL_ZERO);
      repeat (8) send_segment(draw_live_segment());
   endtask

   // random traffic that keeps the connection recoverable, over the idling phases
   task automatic test_live_traffic();
      program_timeouts(FILL_RANDOM);
      set_idling(0, 0);
      repeat (140) send_segment(draw_live_segment());
      program_timeouts(FILL_ONES);
      set_idling(76, 0);
      repeat (140) send_segment(draw_live_segment());
      program_timeouts(FILL_RANDOM);
      set_idling(0, 76);
      repeat (140) send_segment(draw_live_segment());
      program_timeouts(FILL_ZERO);
      set_idling(17, 17);
      repeat (140) send_segment(draw_live_segment());
   endtask

   // long result hold while segments keep coming: the queue fills and stalls input
   task automatic test_backpressure();
      settle_block();
      program_timeouts(FILL_RANDOM);
      set_idling(0, 0);
      hold_requests <= hold_requests + 1;
      repeat (40) send_segment(draw_live_segment());
   endtask

   // close the connection; only one closing path fits in a run, the seed picks it
   task automatic test_teardown();
      logic up;
      logic est;
      set_idling(0, 0);
      // the live side brings both sides to ESTABLISHED
      up  = (conn_side[1] <= ST_ESTABLISHED);
      est = (conn_side[up] == ST_ESTABLISHED);
      send_segment(segment(up, 0, !est, 0, 0));
      send_segment(segment(0, 0, 0, 1, 0));   // originator sends FIN
      if ($urandom_range(1)) begin
         send_segment(segment(1, 0, 1, 0, 0));   // FIN acked: responder half closed
         send_segment(segment(1, 0, 1, 0, 0));
         send_segment(segment(1, 0, 0, 1, 0));   // responder's own FIN
         send_segment(segment(1, 1, 1, 1, 0));
         send_segment(segment(0, 0, 0, 1, 0));
         send_segment(segment(0, 0, 1, 0, 0));   // both to TIME_WAIT
      end else begin
         send_segment(segment(1, 0, 0, 1, 0));   // simultaneous close: CLOSING
         send_segment(segment(1, 0, 1, 1, 0));
         send_segment(segment(0, 0, 0, 0, 0));
         send_segment(segment(0, 0, 1, 0, 0));   // originator's FIN acked -> TIME_WAIT
         send_segment(segment(1, 0, 1, 0, 0));   // CLOSING -> TIME_WAIT
      end
      send_segment(segment(0, 0, 0, 0, 0));   // TIME_WAIT always flags a change
      send_segment(segment(1, 1, 1, 1, 0));
      send_segment(segment(0, 0, 0, 0, 1));   // reset segment
      send_segment(segment(1, 1, 1, 1, 1));
   endtask

   // random segments once the connection is down, RST frequent
   task automatic test_closed_noise();
      program_timeouts(FILL_RANDOM);
      set_idling(17, 17);
      repeat (50) send_segment(segment(1'($urandom_range(1)), 1'($urandom_range(1)),
         1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))));
      program_timeouts(FILL_ONES);
      set_idling(0, 0);
      repeat (50) send_segment(segment(1'($urandom_range(1)), 1'($urandom_range(1)),
         1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))));
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_direction <= 1'b0;
      req_syn_flag  <= 1'b0;
      req_ack_flag  <= 1'b0;
      req_fin_flag  <= 1'b0;
      req_rst_flag  <= 1'b0;
      rsp_ready     <= 1'b0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      conn_side[0]    = ST_LISTEN;
      conn_side[1]    = ST_LISTEN;
      timeout_regs[REG_LISTEN_CLOSED] = RST_LISTEN_CLOSED;
      timeout_regs[REG_SYN_OUT]       = RST_SYN_OUT;
      timeout_regs[REG_SYN_IN]        = RST_SYN_IN;
      timeout_regs[REG_ESTABLISHED]   = RST_ESTABLISHED;
      timeout_regs[REG_PEER_FIN]      = RST_PEER_FIN;
      timeout_regs[REG_FIN_OUT]       = RST_FIN_OUT;
      timeout_regs[REG_LAST_FIN]      = RST_LAST_FIN;
      timeout_regs[REG_TIME_WAIT]     = RST_TIME_WAIT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_handshake();
      test_register_extremes();
      test_live_traffic();
      test_backpressure();
      test_teardown();
      test_closed_noise();

      settle_block();
      if (mismatch_count == 0 && awaited_updates.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
design/tcst_pkg.sv
design/tcst_csr.sv
design/tcst_front.sv
design/tcst_queue.sv
design/tcst_back.sv
design/tcp_connection_state_tracker.sv
sim/tb_tcp_connection_state_tracker.sv
